// ===== sv/rpc_pkg.sv =====
package rpc_pkg;

   // default number of cordic micro-rotations
   localparam int CORDIC_STAGES_DEF = 16;
   // digit steps of the square root row
   localparam int ISQ_STEPS = 32;

   // datapath widths
   localparam int SC_W  = 34;   // sine/cosine cordic x and y
   localparam int VEC_W = 38;   // atan2 cordic x and y
   localparam int ANG_W = 34;   // cordic angle accumulator, 2^32 per turn
   localparam int ISQ_W = 63;   // square root remainder and root

   typedef logic signed [31:0] q_type;     // Q1.30, clamped to +-1
   typedef logic signed [63:0] prod_type;  // Q3.60 products and sums
   typedef logic signed [33:0] wide_type;  // rescaled sums before clamping

   localparam wide_type Q_ONE    = 34'sd1073741824;
   localparam wide_type GAIN_INV = 34'sd652032874;
   localparam logic [ISQ_W-1:0] Q_ONE_SQ = ISQ_W'(1) << 60;

   typedef struct packed {
      logic signed [31:0] local_x;
      logic signed [31:0] local_y;
      logic signed [31:0] local_z;
      logic signed [15:0] local_roll;
      logic signed [15:0] local_pitch;
      logic signed [15:0] local_yaw;
      logic signed [31:0] frame_x;
      logic signed [31:0] frame_y;
      logic signed [31:0] frame_z;
      logic signed [15:0] frame_roll;
      logic signed [15:0] frame_pitch;
      logic signed [15:0] frame_yaw;
   } req_type;

   typedef struct packed {
      logic signed [31:0] global_x;
      logic signed [31:0] global_y;
      logic signed [31:0] global_z;
      logic signed [15:0] global_roll;
      logic signed [15:0] global_pitch;
      logic signed [15:0] global_yaw;
   } rsp_type;

   // arctangent of 2^-k, 2^32 per turn
   function automatic logic [31:0] arc_angle(input logic [4:0] k);
      logic [31:0] a;
      unique case (k)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         5'd30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

   // round half up and drop 30 fraction bits
   function automatic wide_type rnd30(input prod_type p);
      prod_type t;
      t = p + 64'sd536870912;
      return t[63:30];
   endfunction

   function automatic q_type clampq(input wide_type v);
      q_type r;
      if (v > Q_ONE) r = 32'sh40000000;
      else if (v < -Q_ONE) r = 32'shC0000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic prod_type mul(input q_type a, input q_type b);
      return 64'(a) * 64'(b);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -35'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== sv/rpc_if.sv =====
interface rpc_req_if import rpc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rpc_rsp_if import rpc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rpc_delay.sv =====
module rpc_delay #(
   parameter int DEPTH = 1,
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   // shift line, moves with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign q = line_ff[DEPTH-1];

endmodule

// ===== sv/rpc_cordic_cell.sv =====
module rpc_cordic_cell import rpc_pkg::*; #(
   parameter int IDX    = 0,
   parameter bit VECTOR = 1'b0,
   parameter int XW     = SC_W
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [XW-1:0]    x_i,
   input  logic signed [XW-1:0]    y_i,
   input  logic signed [ANG_W-1:0] z_i,
   output logic signed [XW-1:0]    x_ff,
   output logic signed [XW-1:0]    y_ff,
   output logic signed [ANG_W-1:0] z_ff
);

   logic signed [XW-1:0]    xs, ys, x_in, y_in;
   logic signed [ANG_W-1:0] arc, z_in;
   logic                    up;

   assign xs  = x_i >>> IDX;
   assign ys  = y_i >>> IDX;
   assign arc = ANG_W'(arc_angle(5'(IDX)));

   // one micro-rotation, direction from angle residue or from y sign
   always_comb begin
      if (VECTOR) up = (y_i <= 0);
      else up = (z_i >= 0);
      if (up) begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - arc;
      end else begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + arc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

// ===== sv/rpc_isqrt_cell.sv =====
module rpc_isqrt_cell import rpc_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             en,
   input  logic [ISQ_W-1:0] n_i,
   input  logic [ISQ_W-1:0] r_i,
   output logic [ISQ_W-1:0] n_ff,
   output logic [ISQ_W-1:0] r_ff
);

   localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (62 - 2 * STEP);

   logic [ISQ_W-1:0] trial, n_in, r_in;

   assign trial = r_i + BIT;

   // one root digit
   always_comb begin
      if (n_i >= trial) begin
         n_in = n_i - trial;
         r_in = (r_i >> 1) + BIT;
      end else begin
         n_in = n_i;
         r_in = r_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
         r_ff <= r_in;
      end
   end

endmodule

// ===== sv/rigid_pose_compose.sv =====
// Composes a local pose with a frame pose: position plus roll, pitch and yaw in, the
// global pose out. The block is fully pipelined and takes one pose pair per clock while
// the result side keeps up; a stalled result holds the whole pipeline. The pipeline is
// made of the sine/cosine cordic row, the 32-step square root row for pitch and the
// atan2 cordic row, plus the quaternion multiply stages around them. Positions saturate
// to the Q16.16 range and pitch is pinned to a quarter turn at the poles.
module rigid_pose_compose import rpc_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input logic        clock,
   input logic        reset,
   rpc_req_if.sink    req_ch,
   rpc_rsp_if.source  rsp_ch
);

   localparam int N   = CORDIC_STAGES;
   localparam int LAT = 2 * N + 43;
   localparam int LANE_W = 2 * VEC_W + 2;
   localparam int RY_W   = 2 * LANE_W + 2;
   localparam logic signed [15:0] PITCH_POS = 16'sd16384;
   localparam logic signed [15:0] PITCH_NEG = -16'sd16384;

   logic adv;
   logic [LAT-1:0] valid_ff;

   // pipeline moves when the output register is free or being taken
   assign adv = !valid_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], req_ch.valid};
      end
   end

   // half-angle sine/cosine rows, lanes: local r p y, frame r p y
   logic signed [15:0]       ang [6];
   logic signed [SC_W-1:0]   sc_x [6][N+1];
   logic signed [SC_W-1:0]   sc_y [6][N+1];
   logic signed [ANG_W-1:0]  sc_z [6][N+1];

   assign ang[0] = req_ch.data.local_roll;
   assign ang[1] = req_ch.data.local_pitch;
   assign ang[2] = req_ch.data.local_yaw;
   assign ang[3] = req_ch.data.frame_roll;
   assign ang[4] = req_ch.data.frame_pitch;
   assign ang[5] = req_ch.data.frame_yaw;

   for (genvar l = 0; l < 6; l++) begin : g_sc_lane
      assign sc_x[l][0] = GAIN_INV;
      assign sc_y[l][0] = '0;
      assign sc_z[l][0] = {{3{ang[l][15]}}, ang[l], 15'd0};
      for (genvar s = 0; s < N; s++) begin : g_sc_cell
         rpc_cordic_cell #(.IDX(s), .VECTOR(1'b0), .XW(SC_W)) u_cell (
            .clock (clock),
            .en    (adv),
            .x_i   (sc_x[l][s]),
            .y_i   (sc_y[l][s]),
            .z_i   (sc_z[l][s]),
            .x_ff  (sc_x[l][s+1]),
            .y_ff  (sc_y[l][s+1]),
            .z_ff  (sc_z[l][s+1])
         );
      end
   end

   // positions ride alongside until the rotation matrix is ready
   logic [191:0] pos_d;

   rpc_delay #(.DEPTH(N + 5), .WIDTH(192)) u_pos_delay (
      .clock (clock),
      .en    (adv),
      .d     ({req_ch.data.local_x, req_ch.data.local_y, req_ch.data.local_z,
               req_ch.data.frame_x, req_ch.data.frame_y, req_ch.data.frame_z}),
      .q     (pos_d)
   );

   // stage a: clamp and first products
   q_type    cs_c [6];
   q_type    cs_s [6];
   prod_type pa_ff [2][4];
   q_type    cy_ff [2];
   q_type    sy_ff [2];

   always_comb begin
      for (int l = 0; l < 6; l++) begin
         cs_c[l] = clampq(sc_x[l][N]);
         cs_s[l] = clampq(sc_y[l][N]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int q = 0; q < 2; q++) begin
            pa_ff[q][0] <= mul(cs_c[3*q], cs_c[3*q+1]);
            pa_ff[q][1] <= mul(cs_s[3*q], cs_s[3*q+1]);
            pa_ff[q][2] <= mul(cs_s[3*q], cs_c[3*q+1]);
            pa_ff[q][3] <= mul(cs_c[3*q], cs_s[3*q+1]);
            cy_ff[q]    <= cs_c[3*q+2];
            sy_ff[q]    <= cs_s[3*q+2];
         end
      end
   end

   // stage b: rescale and multiply by yaw terms
   q_type    mqa [2][4];
   prod_type pb_ff [2][8];

   always_comb begin
      for (int q = 0; q < 2; q++) begin
         for (int k = 0; k < 4; k++) begin
            mqa[q][k] = q_type'(rnd30(pa_ff[q][k]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int q = 0; q < 2; q++) begin
            pb_ff[q][0] <= mul(mqa[q][0], cy_ff[q]);
            pb_ff[q][1] <= mul(mqa[q][1], sy_ff[q]);
            pb_ff[q][2] <= mul(mqa[q][2], cy_ff[q]);
            pb_ff[q][3] <= mul(mqa[q][3], sy_ff[q]);
            pb_ff[q][4] <= mul(mqa[q][0], sy_ff[q]);
            pb_ff[q][5] <= mul(mqa[q][1], cy_ff[q]);
            pb_ff[q][6] <= mul(mqa[q][3], cy_ff[q]);
            pb_ff[q][7] <= mul(mqa[q][2], sy_ff[q]);
         end
      end
   end

   // stage c: quaternions, index 0 local, 1 frame; members w x y z
   q_type quat_ff [2][4];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int q = 0; q < 2; q++) begin
            quat_ff[q][0] <= clampq(rnd30(pb_ff[q][0] + pb_ff[q][1]));
            quat_ff[q][1] <= clampq(rnd30(pb_ff[q][2] - pb_ff[q][3]));
            quat_ff[q][2] <= clampq(rnd30(pb_ff[q][6] + pb_ff[q][7]));
            quat_ff[q][3] <= clampq(rnd30(pb_ff[q][4] - pb_ff[q][5]));
         end
      end
   end

   // stage d: frame times local products and frame matrix products
   prod_type gp_ff [4][4];
   prod_type mp_ff [9];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               gp_ff[i][j] <= mul(quat_ff[1][i], quat_ff[0][j]);
            end
         end
         mp_ff[0] <= mul(quat_ff[1][2], quat_ff[1][2]);
         mp_ff[1] <= mul(quat_ff[1][3], quat_ff[1][3]);
         mp_ff[2] <= mul(quat_ff[1][1], quat_ff[1][2]);
         mp_ff[3] <= mul(quat_ff[1][0], quat_ff[1][3]);
         mp_ff[4] <= mul(quat_ff[1][1], quat_ff[1][3]);
         mp_ff[5] <= mul(quat_ff[1][0], quat_ff[1][2]);
         mp_ff[6] <= mul(quat_ff[1][1], quat_ff[1][1]);
         mp_ff[7] <= mul(quat_ff[1][2], quat_ff[1][3]);
         mp_ff[8] <= mul(quat_ff[1][0], quat_ff[1][1]);
      end
   end

   // stage e: partial sums of the product quaternion, rotation matrix
   prod_type gs_ff [8];
   q_type    rot_ff [3][3];

   always_ff @(posedge clock) begin
      if (adv) begin
         gs_ff[0] <= gp_ff[0][1] + gp_ff[1][0];
         gs_ff[1] <= gp_ff[2][3] - gp_ff[3][2];
         gs_ff[2] <= gp_ff[0][2] - gp_ff[1][3];
         gs_ff[3] <= gp_ff[2][0] + gp_ff[3][1];
         gs_ff[4] <= gp_ff[0][3] + gp_ff[1][2];
         gs_ff[5] <= gp_ff[3][0] - gp_ff[2][1];
         gs_ff[6] <= gp_ff[0][0] - gp_ff[1][1];
         gs_ff[7] <= 64'sd0 - gp_ff[2][2] - gp_ff[3][3];
         rot_ff[0][0] <= clampq(Q_ONE - rnd30((mp_ff[0] + mp_ff[1]) <<< 1));
         rot_ff[0][1] <= clampq(rnd30((mp_ff[2] - mp_ff[3]) <<< 1));
         rot_ff[0][2] <= clampq(rnd30((mp_ff[4] + mp_ff[5]) <<< 1));
         rot_ff[1][0] <= clampq(rnd30((mp_ff[2] + mp_ff[3]) <<< 1));
         rot_ff[1][1] <= clampq(Q_ONE - rnd30((mp_ff[6] + mp_ff[1]) <<< 1));
         rot_ff[1][2] <= clampq(rnd30((mp_ff[7] - mp_ff[8]) <<< 1));
         rot_ff[2][0] <= clampq(rnd30((mp_ff[4] - mp_ff[5]) <<< 1));
         rot_ff[2][1] <= clampq(rnd30((mp_ff[7] + mp_ff[8]) <<< 1));
         rot_ff[2][2] <= clampq(Q_ONE - rnd30((mp_ff[6] + mp_ff[0]) <<< 1));
      end
   end

   // stage f: global quaternion w x y z, matrix times local position
   q_type    lp [3];
   q_type    g_ff [4];
   prod_type pp_ff [3][3];
   q_type    fp_ff [3];

   assign lp[0] = pos_d[191:160];
   assign lp[1] = pos_d[159:128];
   assign lp[2] = pos_d[127:96];

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff[0] <= clampq(rnd30(gs_ff[6] + gs_ff[7]));
         g_ff[1] <= clampq(rnd30(gs_ff[0] + gs_ff[1]));
         g_ff[2] <= clampq(rnd30(gs_ff[2] + gs_ff[3]));
         g_ff[3] <= clampq(rnd30(gs_ff[4] + gs_ff[5]));
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pp_ff[i][j] <= mul(rot_ff[i][j], lp[j]);
            end
         end
         fp_ff[0] <= pos_d[95:64];
         fp_ff[1] <= pos_d[63:32];
         fp_ff[2] <= pos_d[31:0];
      end
   end

   // stage g: euler products, saturated global position
   prod_type ep_ff [9];
   logic signed [31:0] gpos_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         ep_ff[0] <= mul(g_ff[0], g_ff[1]);
         ep_ff[1] <= mul(g_ff[2], g_ff[3]);
         ep_ff[2] <= mul(g_ff[1], g_ff[1]);
         ep_ff[3] <= mul(g_ff[2], g_ff[2]);
         ep_ff[4] <= mul(g_ff[0], g_ff[2]);
         ep_ff[5] <= mul(g_ff[3], g_ff[1]);
         ep_ff[6] <= mul(g_ff[0], g_ff[3]);
         ep_ff[7] <= mul(g_ff[1], g_ff[2]);
         ep_ff[8] <= mul(g_ff[3], g_ff[3]);
         for (int i = 0; i < 3; i++) begin
            gpos_ff[i] <= sat32(35'(fp_ff[i])
                                + 35'(rnd30(pp_ff[i][0] + pp_ff[i][1] + pp_ff[i][2])));
         end
      end
   end

   // stage h: sines and cosines of the global angles
   wide_type sinr_ff, cosr_ff, sinp_ff, siny_ff, cosy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sinr_ff <= rnd30((ep_ff[0] + ep_ff[1]) <<< 1);
         cosr_ff <= Q_ONE - rnd30((ep_ff[2] + ep_ff[3]) <<< 1);
         sinp_ff <= rnd30((ep_ff[4] - ep_ff[5]) <<< 1);
         siny_ff <= rnd30((ep_ff[6] + ep_ff[7]) <<< 1);
         cosy_ff <= Q_ONE - rnd30((ep_ff[3] + ep_ff[8]) <<< 1);
      end
   end

   // stage i: pole test, radicand for pitch, half-turn fold for roll and yaw
   prod_type           sinp_sq;
   logic               r_neg, y_neg;
   logic [ISQ_W-1:0]   rad_ff;
   wide_type           sinp_i_ff;
   logic [RY_W-1:0]    ry_ff;

   assign sinp_sq = mul(sinp_ff[31:0], sinp_ff[31:0]);
   assign r_neg   = cosr_ff < 0;
   assign y_neg   = cosy_ff < 0;

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff    <= Q_ONE_SQ - sinp_sq[ISQ_W-1:0];
         sinp_i_ff <= sinp_ff;
         ry_ff <= {sinp_ff >= Q_ONE, sinp_ff <= -Q_ONE,
                   VEC_W'(r_neg ? -cosr_ff : cosr_ff), VEC_W'(r_neg ? -sinr_ff : sinr_ff),
                   r_neg, (cosr_ff == 0) && (sinr_ff == 0),
                   VEC_W'(y_neg ? -cosy_ff : cosy_ff), VEC_W'(y_neg ? -siny_ff : siny_ff),
                   y_neg, (cosy_ff == 0) && (siny_ff == 0)};
      end
   end

   // square root row for the pitch cosine
   logic [ISQ_W-1:0] sq_n [ISQ_STEPS+1];
   logic [ISQ_W-1:0] sq_r [ISQ_STEPS+1];

   assign sq_n[0] = rad_ff;
   assign sq_r[0] = '0;

   for (genvar s = 0; s < ISQ_STEPS; s++) begin : g_isq_cell
      rpc_isqrt_cell #(.STEP(s)) u_cell (
         .clock (clock),
         .en    (adv),
         .n_i   (sq_n[s]),
         .r_i   (sq_r[s]),
         .n_ff  (sq_n[s+1]),
         .r_ff  (sq_r[s+1])
      );
   end

   logic [SC_W-1:0]  sinp_d;
   logic [RY_W-1:0]  ry_d;

   rpc_delay #(.DEPTH(ISQ_STEPS), .WIDTH(SC_W)) u_sinp_delay (
      .clock (clock),
      .en    (adv),
      .d     (sinp_i_ff),
      .q     (sinp_d)
   );

   rpc_delay #(.DEPTH(ISQ_STEPS + 1), .WIDTH(RY_W)) u_ry_delay (
      .clock (clock),
      .en    (adv),
      .d     (ry_ff),
      .q     (ry_d)
   );

   // stage j: pitch vector, x is never negative
   logic signed [VEC_W-1:0] pj_x_ff, pj_y_ff;
   logic                    pj_zero_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pj_x_ff    <= VEC_W'(sq_r[ISQ_STEPS][31:0]);
         pj_y_ff    <= VEC_W'($signed(sinp_d));
         pj_zero_ff <= (sinp_d == '0) && (sq_r[ISQ_STEPS] == '0);
      end
   end

   // atan2 rows, lanes: roll, pitch, yaw
   logic signed [VEC_W-1:0] vec_x [3][N+1];
   logic signed [VEC_W-1:0] vec_y [3][N+1];
   logic signed [ANG_W-1:0] vec_z [3][N+1];

   assign vec_x[0][0] = ry_d[RY_W-3 -: VEC_W];
   assign vec_y[0][0] = ry_d[RY_W-3-VEC_W -: VEC_W];
   assign vec_z[0][0] = ry_d[LANE_W+1] ? ANG_W'(33'h080000000) : '0;
   assign vec_x[1][0] = pj_x_ff;
   assign vec_y[1][0] = pj_y_ff;
   assign vec_z[1][0] = '0;
   assign vec_x[2][0] = ry_d[LANE_W-1 -: VEC_W];
   assign vec_y[2][0] = ry_d[LANE_W-1-VEC_W -: VEC_W];
   assign vec_z[2][0] = ry_d[1] ? ANG_W'(33'h080000000) : '0;

   for (genvar l = 0; l < 3; l++) begin : g_vec_lane
      for (genvar s = 0; s < N; s++) begin : g_vec_cell
         rpc_cordic_cell #(.IDX(s), .VECTOR(1'b1), .XW(VEC_W)) u_cell (
            .clock (clock),
            .en    (adv),
            .x_i   (vec_x[l][s]),
            .y_i   (vec_y[l][s]),
            .z_i   (vec_z[l][s]),
            .x_ff  (vec_x[l][s+1]),
            .y_ff  (vec_y[l][s+1]),
            .z_ff  (vec_z[l][s+1])
         );
      end
   end

   // zero-vector and pole flags beside the atan2 rows
   logic [4:0] flag_d;

   rpc_delay #(.DEPTH(N), .WIDTH(5)) u_flag_delay (
      .clock (clock),
      .en    (adv),
      .d     ({ry_d[RY_W-1], ry_d[RY_W-2], ry_d[LANE_W], pj_zero_ff, ry_d[0]}),
      .q     (flag_d)
   );

   logic [95:0] gpos_d;

   rpc_delay #(.DEPTH(N + 35), .WIDTH(96)) u_gpos_delay (
      .clock (clock),
      .en    (adv),
      .d     ({gpos_ff[0], gpos_ff[1], gpos_ff[2]}),
      .q     (gpos_d)
   );

   // stage k: round the angles to 16 bits and fill the output register
   logic [31:0] zr [3];
   logic [15:0] ang_out [3];
   rsp_type     out_in, out_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         zr[l] = vec_z[l][N][31:0] + 32'h00008000;
         ang_out[l] = flag_d[2-l] ? 16'd0 : zr[l][31:16];
      end
      out_in.global_x    = gpos_d[95:64];
      out_in.global_y    = gpos_d[63:32];
      out_in.global_z    = gpos_d[31:0];
      out_in.global_roll = ang_out[0];
      out_in.global_yaw  = ang_out[2];
      priority if (flag_d[4]) out_in.global_pitch = PITCH_POS;
      else if (flag_d[3]) out_in.global_pitch = PITCH_NEG;
      else out_in.global_pitch = ang_out[1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid = valid_ff[LAT-1];
   assign rsp_ch.data  = out_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_fold_positive: assert property (@(posedge clock) disable iff (reset)
      valid_ff[N+41] |-> (vec_x[0][0] >= 0) && (vec_x[2][0] >= 0))
      else $error("atan2 vector not folded into right half plane");
`endif

endmodule

// ===== sim/pose_scoreboard.sv =====
package pose_scoreboard_pkg;
   import rpc_pkg::*;

   // cordic angle step for a micro-rotation of 2^-k, 2^32 per turn
   function automatic longint arc_step(input int k);
      case (k)
         0:  return 64'h20000000;
         1:  return 64'h12E4051E;
         2:  return 64'h09FB385B;
         3:  return 64'h051111D4;
         4:  return 64'h028B0D43;
         5:  return 64'h0145D7E1;
         6:  return 64'h00A2F61E;
         7:  return 64'h00517C55;
         8:  return 64'h0028BE53;
         9:  return 64'h00145F2F;
         10: return 64'h000A2F98;
         11: return 64'h000517CC;
         12: return 64'h00028BE6;
         13: return 64'h000145F3;
         14: return 64'h0000A2FA;
         15: return 64'h0000517D;
         16: return 64'h000028BE;
         17: return 64'h0000145F;
         18: return 64'h00000A30;
         19: return 64'h00000518;
         20: return 64'h0000028C;
         21: return 64'h00000146;
         22: return 64'h000000A3;
         23: return 64'h00000051;
         24: return 64'h00000029;
         25: return 64'h00000014;
         26: return 64'h0000000A;
         27: return 64'h00000005;
         28: return 64'h00000003;
         29: return 64'h00000001;
         30: return 64'h00000001;
         default: return 64'h0;
      endcase
   endfunction

   class pose_scoreboard;
      int stages;
      rsp_type pending[$];
      int n_checked;
      int n_errors;

      function new(int st);
         stages = st;
         n_checked = 0;
         n_errors = 0;
      endfunction

      static function longint one_q();
         return 64'sd1 << 30;
      endfunction

      // round half up, drop 30 fraction bits
      static function longint round30(longint p);
         return (p + (64'sd1 << 29)) >>> 30;
      endfunction

      static function longint limit_unit(longint v);
         if (v > one_q()) return one_q();
         if (v < -one_q()) return -one_q();
         return v;
      endfunction

      static function longint qmul(longint a, longint b);
         return round30(a * b);
      endfunction

      function void half_trig(longint ang, output longint c, output longint s);
         longint x, y, z, dx, dy;
         x = 652032874;
         y = 0;
         z = ang * 32768;
         for (int i = 0; i < stages; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (z >= 0) begin
               x -= dx; y += dy; z -= arc_step(i & 31);
            end else begin
               x += dx; y -= dy; z += arc_step(i & 31);
            end
         end
         c = limit_unit(x);
         s = limit_unit(y);
      endfunction

      function logic [15:0] vector_angle(longint y, longint x);
         logic [31:0] z;
         longint dx, dy;
         z = 0;
         if (x == 0 && y == 0) return 16'h0;
         if (x < 0) begin
            x = -x; y = -y; z = 32'h80000000;
         end
         for (int i = 0; i < stages; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (y > 0) begin
               x += dx; y -= dy; z += 32'(arc_step(i & 31));
            end else begin
               x -= dx; y += dy; z -= 32'(arc_step(i & 31));
            end
         end
         z = z + 32'h8000;
         return z[31:16];
      endfunction

      static function longint root64(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      // quaternion as w, x, y, z
      function void to_quat(longint rl, longint pt, longint yw, output longint q[4]);
         longint cr, sr, cp, sp, cy, sy;
         half_trig(rl, cr, sr);
         half_trig(pt, cp, sp);
         half_trig(yw, cy, sy);
         q[0] = limit_unit(round30(qmul(cr, cp) * cy + qmul(sr, sp) * sy));
         q[1] = limit_unit(round30(qmul(sr, cp) * cy - qmul(cr, sp) * sy));
         q[2] = limit_unit(round30(qmul(cr, sp) * cy + qmul(sr, cp) * sy));
         q[3] = limit_unit(round30(qmul(cr, cp) * sy - qmul(sr, sp) * cy));
      endfunction

      function rsp_type compose(req_type r);
         longint a[4], b[4], g[4], m[3][3], lp[3], fp[3];
         longint sr, cr, sp, sy, cy, rot, sum;
         rsp_type o;
         to_quat(r.local_roll, r.local_pitch, r.local_yaw, b);
         to_quat(r.frame_roll, r.frame_pitch, r.frame_yaw, a);
         g[1] = limit_unit(round30(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]));
         g[2] = limit_unit(round30(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]));
         g[3] = limit_unit(round30(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]));
         g[0] = limit_unit(round30(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]));
         sr = round30(2 * (g[0]*g[1] + g[2]*g[3]));
         cr = one_q() - round30(2 * (g[1]*g[1] + g[2]*g[2]));
         sp = round30(2 * (g[0]*g[2] - g[3]*g[1]));
         sy = round30(2 * (g[0]*g[3] + g[1]*g[2]));
         cy = one_q() - round30(2 * (g[2]*g[2] + g[3]*g[3]));
         o.global_roll = vector_angle(sr, cr);
         // pitch pinned at the poles
         if (sp >= one_q()) o.global_pitch = 16'sd16384;
         else if (sp <= -one_q()) o.global_pitch = -16'sd16384;
         else o.global_pitch = vector_angle(sp, root64((64'd1 << 60) - sp * sp));
         o.global_yaw = vector_angle(sy, cy);
         // rotation matrix of the frame quaternion
         m[0][0] = limit_unit(one_q() - round30(2 * (a[2]*a[2] + a[3]*a[3])));
         m[0][1] = limit_unit(round30(2 * (a[1]*a[2] - a[0]*a[3])));
         m[0][2] = limit_unit(round30(2 * (a[1]*a[3] + a[0]*a[2])));
         m[1][0] = limit_unit(round30(2 * (a[1]*a[2] + a[0]*a[3])));
         m[1][1] = limit_unit(one_q() - round30(2 * (a[1]*a[1] + a[3]*a[3])));
         m[1][2] = limit_unit(round30(2 * (a[2]*a[3] - a[0]*a[1])));
         m[2][0] = limit_unit(round30(2 * (a[1]*a[3] - a[0]*a[2])));
         m[2][1] = limit_unit(round30(2 * (a[2]*a[3] + a[0]*a[1])));
         m[2][2] = limit_unit(one_q() - round30(2 * (a[1]*a[1] + a[2]*a[2])));
         lp = '{r.local_x, r.local_y, r.local_z};
         fp = '{r.frame_x, r.frame_y, r.frame_z};
         for (int i = 0; i < 3; i++) begin
            rot = round30(m[i][0]*lp[0] + m[i][1]*lp[1] + m[i][2]*lp[2]);
            sum = fp[i] + rot;
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            case (i)
               0: o.global_x = sum[31:0];
               1: o.global_y = sum[31:0];
               default: o.global_z = sum[31:0];
            endcase
         end
         return o;
      endfunction

      function void note_request(req_type r);
         pending.push_back(compose(r));
      endfunction

      function void check_pose(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected pose result %h", got);
            n_errors++;
            return;
         end
         e = pending.pop_front();
         n_checked++;
         if (got.global_x !== e.global_x) begin
            $error("global_x expected %0d got %0d", e.global_x, got.global_x); n_errors++;
         end
         if (got.global_y !== e.global_y) begin
            $error("global_y expected %0d got %0d", e.global_y, got.global_y); n_errors++;
         end
         if (got.global_z !== e.global_z) begin
            $error("global_z expected %0d got %0d", e.global_z, got.global_z); n_errors++;
         end
         if (got.global_roll !== e.global_roll) begin
            $error("global_roll expected %0d got %0d", e.global_roll, got.global_roll);
            n_errors++;
         end
         if (got.global_pitch !== e.global_pitch) begin
            $error("global_pitch expected %0d got %0d", e.global_pitch, got.global_pitch);
            n_errors++;
         end
         if (got.global_yaw !== e.global_yaw) begin
            $error("global_yaw expected %0d got %0d", e.global_yaw, got.global_yaw);
            n_errors++;
         end
      endfunction
   endclass
endpackage

// ===== sim/rigid_pose_compose_test.sv =====
module rigid_pose_compose_test;
   import rpc_pkg::*;
   import pose_scoreboard_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 2 * CORDIC_STAGES_DEF + 43;
   localparam int N_RANDOM = 2000;
   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   rpc_req_if req_ch ();
   rpc_rsp_if rsp_ch ();

   rigid_pose_compose u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   pose_scoreboard board;
   int idle_cycles;
   int n_sent;
   int n_poles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [15:0] pick_angle();
      logic [15:0] set[10] = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF,
                               16'h0001, 16'hFFFF, 16'h2000, 16'hE000, 16'h8001};
      if ($urandom_range(0, 3) == 0) return set[$urandom_range(0, 9)];
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_pos();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      if (p < 4) return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
      return $urandom;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.local_x = pick_pos(); r.local_y = pick_pos(); r.local_z = pick_pos();
      r.frame_x = pick_pos(); r.frame_y = pick_pos(); r.frame_z = pick_pos();
      r.local_roll = pick_angle(); r.local_pitch = pick_angle();
      r.local_yaw = pick_angle(); r.frame_roll = pick_angle();
      r.frame_pitch = pick_angle(); r.frame_yaw = pick_angle();
      return r;
   endfunction

   // present one request and hold it until taken; valid stays up between
   // back-to-back requests and drops only for a gap
   task automatic send_request(req_type r);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      n_sent++;
   endtask

   // request and result acceptance, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            board.note_request(req_ch.data);
            if (req_ch.data.local_pitch == 16'h4000 || req_ch.data.frame_pitch == 16'h4000
                || req_ch.data.local_pitch == 16'hC000 || req_ch.data.frame_pitch == 16'hC000)
               n_poles++;
         end
         if (rsp_ch.valid && rsp_ch.ready) board.check_pose(rsp_ch.data);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("rigid_pose_compose test failed");
            $finish;
         end
      end
   end

   // result side stalls at random, with some stretches held ready
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         if ($urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap_len() + 1) @(negedge clock);
         end
      end
   end

   initial begin
      req_type r;
      logic [15:0] angles[6];
      angles = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'hFFFF};
      board = new(CORDIC_STAGES_DEF);
      idle_cycles = 0;
      n_sent = 0;
      n_poles = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero pose, field extremes, poles, half turns, saturation
      send_request('0);
      foreach (angles[i]) begin
         r = '0;
         r.local_x = 32'sh00010000;
         r.local_roll = angles[i]; r.local_pitch = angles[i]; r.local_yaw = angles[i];
         r.frame_pitch = angles[(i + 1) % 6];
         send_request(r);
      end
      r = '{default: '1};
      send_request(r);
      r = '0;
      r.local_x = 32'sh7FFFFFFF; r.local_y = 32'sh7FFFFFFF; r.local_z = 32'sh7FFFFFFF;
      r.frame_x = 32'sh7FFFFFFF; r.frame_y = 32'sh7FFFFFFF; r.frame_z = 32'sh7FFFFFFF;
      send_request(r);
      r.local_x = 32'sh80000000; r.local_y = 32'sh80000000; r.local_z = 32'sh80000000;
      r.frame_x = 32'sh80000000; r.frame_y = 32'sh80000000; r.frame_z = 32'sh80000000;
      send_request(r);
      r.frame_yaw = 16'h8000; r.frame_roll = 16'h4000;
      send_request(r);
      // frame and local pitch adding to the pole
      r = '0;
      r.local_pitch = 16'h2000; r.frame_pitch = 16'h2000;
      send_request(r);
      r.local_pitch = 16'hE000; r.frame_pitch = 16'hE000;
      send_request(r);
      // roll over a half turn sends atan2 down the negative x branch
      r = '0;
      r.local_roll = 16'h6000; r.frame_roll = 16'h3000; r.local_y = 32'sh00050000;
      send_request(r);

      // random poses
      repeat (N_RANDOM) send_request(random_request());
      req_ch.valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("sent %0d pose pairs (%0d with a pole pitch), checked %0d results",
               n_sent, n_poles, board.n_checked);
      if (board.n_errors == 0 && board.pending.size() == 0)
         $display("rigid_pose_compose test passed");
      else
         $display("rigid_pose_compose test failed");
      $finish;
   end
endmodule

// ===== rigid_pose_compose.f =====
sv/rpc_pkg.sv
sv/rpc_if.sv
sv/rpc_delay.sv
sv/rpc_cordic_cell.sv
sv/rpc_isqrt_cell.sv
sv/rigid_pose_compose.sv
sim/pose_scoreboard.sv
sim/rigid_pose_compose_test.sv
